// ===== sv/tcb_pkg.sv =====
// Package of the timer counter bank: register offsets, control bit positions,
// operation codes and the result type. It depends on nothing else.
`timescale 1ns / 1ps

package tcb_pkg;

  // Default number of timers in the bank (1 to 16).
  localparam int TCB_TIMER_COUNT = 2;

  // Address split: upper bits pick the timer, low bits pick the register.
  localparam int ADDR_W     = 16;
  localparam int OFFSET_W   = 12;
  localparam int INDEX_W    = ADDR_W - OFFSET_W;
  localparam int DATA_W     = 32;
  localparam int IRQ_W      = 16;
  localparam int STEP_W     = 8;

  localparam logic [OFFSET_W-1:0] OFFSET_CONTROL = 12'h000;
  localparam logic [OFFSET_W-1:0] OFFSET_DIVISOR = 12'h004;
  localparam logic [OFFSET_W-1:0] OFFSET_COUNTER = 12'h008;

  // Control register bit positions.
  localparam int BIT_EXPIRED = 0;
  localparam int BIT_ENABLE  = 1;

  localparam logic [DATA_W-1:0] RESET_VALUE = 32'hFFFF_FFFF;
  localparam logic [STEP_W-1:0] STEP_RESET  = 8'd1;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // One result item as it waits in the output stage.
  typedef struct packed {
    logic [IRQ_W-1:0]  irq_lines;
    logic              bus_error;
    logic [DATA_W-1:0] read_data;
  } result_t;

endpackage

// ===== sv/timer_counter_bank.sv =====
// Bank of reloading down-counter timers behind a register bus, top level.
// Depends on tcb_pkg for offsets, control bits, operation codes and types.
//
// Usage:
//   The s_ channel carries one bus read, bus write or tick per transfer. The
//   operation code travels in s_tuser; s_tdata holds the address (timer index
//   in bits 15..12, register offset in bits 11..0) and the write data.
//   Registers per timer: control at offset 0 (bit 0 expired, bit 1 enable),
//   divisor at 4 and counter at 8. Writing the divisor also loads the
//   counter. A tick lowers every counter by the tick step; a counter at or
//   below the step has divisor minus step added and sets its expired bit.
//   The m_ channel returns one result per transfer: read data and the
//   interrupt lines in m_tdata, the bus error flag in m_tuser.
//   The cfg_ channel writes the 8-bit tick step and is always ready; the user
//   writes it only while the block is idle, which the block does not enforce.
// Result path and throughput:
//   Each result is registered in the head or the skid register. One item is
//   taken every cycle while s_tready is high, all timers updating in its cycle.
// Reset and stalls:
//   rst clears all control bits, sets divisors and counters to all ones and
//   the tick step to 1. When the receiver stalls, the two-entry output stage
//   takes one more item, then s_tready drops until a result is taken.
`timescale 1ns / 1ps

module timer_counter_bank
  import tcb_pkg::*;
#(
  parameter int TIMER_COUNT = TCB_TIMER_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  // Input items.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [47:0]         s_tdata,   // [15:0] address, [47:16] write_data
  input  logic [1:0]          s_tuser,   // [1:0] operation
  // Result items.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata,   // [31:0] read_data, [47:32] irq_lines
  output logic [0:0]          m_tuser,   // [0] bus_error
  // Tick step register write.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [STEP_W-1:0]   cfg_data
);

  // Timer state.
  logic [1:0]        control [TIMER_COUNT];
  logic [DATA_W-1:0] divisor [TIMER_COUNT];
  logic [DATA_W-1:0] count   [TIMER_COUNT];
  logic [1:0]        control_next [TIMER_COUNT];
  logic [DATA_W-1:0] divisor_next [TIMER_COUNT];
  logic [DATA_W-1:0] count_next   [TIMER_COUNT];
  logic [STEP_W-1:0] tick_step;

  // Output stage: head register and skid register.
  result_t head, skid;
  logic    head_valid, skid_valid;
  result_t result_next;

  logic              accept;
  logic              pop;
  op_t               op;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  logic [INDEX_W-1:0]  timer_index;
  logic [OFFSET_W-1:0] offset;
  logic [DATA_W-1:0] step_ext;

  assign cfg_ready  = 1'b1;
  assign s_tready   = ~skid_valid;
  assign accept     = s_tvalid & s_tready;
  assign pop        = head_valid & m_tready;

  assign op          = op_t'(s_tuser);
  assign address     = s_tdata[ADDR_W-1:0];
  assign write_data  = s_tdata[ADDR_W +: DATA_W];
  assign timer_index = address[ADDR_W-1:OFFSET_W];
  assign offset      = address[OFFSET_W-1:0];
  assign step_ext    = {{(DATA_W-STEP_W){1'b0}}, tick_step};

  // Register access, tick update and result for the item on the input.
  always_comb begin
    logic              hit;
    logic              index_ok;
    logic              offset_ok;
    logic [DATA_W-1:0] rdata;
    result_next = '0;
    rdata       = '0;
    index_ok    = 1'b0;
    offset_ok   = (offset == OFFSET_CONTROL) || (offset == OFFSET_DIVISOR) ||
                  ((offset == OFFSET_COUNTER) && (op == OP_READ));
    for (int t = 0; t < TIMER_COUNT; t++) begin
      hit             = (timer_index == INDEX_W'(t));
      index_ok        = index_ok | hit;
      control_next[t] = control[t];
      divisor_next[t] = divisor[t];
      count_next[t]   = count[t];
      case (op)
        OP_READ: begin
          if (hit) begin
            if (offset == OFFSET_CONTROL) begin
              rdata = rdata | {{(DATA_W-2){1'b0}}, control[t]};
            end else if (offset == OFFSET_DIVISOR) begin
              rdata = rdata | divisor[t];
            end else if (offset == OFFSET_COUNTER) begin
              rdata = rdata | count[t];
            end
          end
        end
        OP_WRITE: begin
          if (hit) begin
            if (offset == OFFSET_CONTROL) begin
              control_next[t] = write_data[1:0];
            end else if (offset == OFFSET_DIVISOR) begin
              divisor_next[t] = write_data;
              count_next[t]   = write_data;
            end
          end
        end
        OP_TICK: begin
          // Reload by divisor minus step when the counter would reach or pass zero.
          if (count[t] <= step_ext) begin
            count_next[t]               = count[t] + (divisor[t] - step_ext);
            control_next[t][BIT_EXPIRED] = 1'b1;
          end else begin
            count_next[t] = count[t] - step_ext;
          end
        end
        default: begin
        end
      endcase
      // Interrupt lines are taken after the update.
      if (t < IRQ_W) begin
        result_next.irq_lines[t] = control_next[t][BIT_ENABLE] &
                                   control_next[t][BIT_EXPIRED];
      end
    end
    if ((op == OP_READ) || (op == OP_WRITE)) begin
      result_next.bus_error = ~(index_ok & offset_ok);
      if (op == OP_READ && index_ok && offset_ok) begin
        result_next.read_data = rdata;
      end
    end
  end

  // Timer state and tick step registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= STEP_RESET;
      for (int t = 0; t < TIMER_COUNT; t++) begin
        control[t] <= '0;
        divisor[t] <= RESET_VALUE;
        count[t]   <= RESET_VALUE;
      end
    end else begin
      if (cfg_valid) begin
        tick_step <= cfg_data;
      end
      if (accept) begin
        for (int t = 0; t < TIMER_COUNT; t++) begin
          control[t] <= control_next[t];
          divisor[t] <= divisor_next[t];
          count[t]   <= count_next[t];
        end
      end
    end
  end

  // Output stage control: the skid register fills only while the head stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else if (!accept) begin
          head_valid <= 1'b0;
        end
      end else if (accept) begin
        if (head_valid) begin
          skid_valid <= 1'b1;
        end else begin
          head_valid <= 1'b1;
        end
      end
    end
  end

  // Output stage payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
      end else if (accept) begin
        head <= result_next;
      end
    end else if (accept) begin
      if (head_valid) begin
        skid <= result_next;
      end else begin
        head <= result_next;
      end
    end
  end

  assign m_tvalid = head_valid;
  assign m_tdata  = {head.irq_lines, head.read_data};
  assign m_tuser  = head.bus_error;

endmodule
